// ===== rtl/pfp_pkg.sv =====
//------------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants of the packet frame parser.
//------------------------------------------------------------------------------
package pfp_pkg;

    localparam logic [7:0]  HEAD_MAGIC = 8'h81;
    localparam logic [7:0]  TAIL_MAGIC = 8'h7e;
    localparam logic [15:0] HDR_SIZE   = 16'd28;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_TRUNC    = 4'd1,
        ST_SHORT    = 4'd2,
        ST_HEAD     = 4'd3,
        ST_TAIL     = 4'd4,
        ST_HSUM     = 4'd5,
        ST_OFFSET   = 4'd6,
        ST_OVERRUN  = 4'd7,
        ST_BSUM     = 4'd8,
        ST_WS_SHORT = 4'd9,
        ST_FIN      = 4'd10,
        ST_OPCODE   = 4'd11,
        ST_MASK     = 4'd12
    } status_t;

    localparam logic [1:0] REG_WS_MODE = 2'd0;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [3:0]  status;
        logic [7:0]  packet_type;
        logic [7:0]  packet_flag;
        logic [15:0] route;
        logic [31:0] sequence_no;
        logic [7:0]  retry_count;
        logic [31:0] user_id;
        logic [31:0] session_key;
        logic [31:0] protocol_word;
        logic [15:0] decoded_length;
    } record_t;

    // Everything the back end needs to finish a buffer
    typedef struct packed {
        logic        ws_active;
        logic        ws_short;
        logic [3:0]  error_code;
        logic        frame_over;
        logic [31:0] size;
        logic [15:0] packet_length;
        logic [7:0]  head_byte;
        logic [7:0]  tail_byte;
        logic [7:0]  header_sum;
        logic [7:0]  expected_header_sum;
        logic [7:0]  body_sum;
        logic [7:0]  expected_body_sum;
        logic [7:0]  body_start;
        logic [15:0] body_length;
        logic [63:0] hf0;
        logic [63:0] hf1;
        logic [63:0] hf2;
    } summary_t;

    // Item passed from front to back
    typedef struct packed {
        logic        last;
        logic [7:0]  body_byte;
        summary_t    sum;
    } work_t;

    function automatic logic [7:0] salt(input logic [2:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                3'd0: r = 8'h74;
                3'd1: r = 8'he8;
                3'd2: r = 8'ha6;
                3'd3: r = 8'h97;
                3'd4: r = 8'h2e;
                3'd5: r = 8'h3c;
                3'd6: r = 8'h59;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    // mod 7 of a 17-bit value, folded by 8 = 1 mod 7
    function automatic logic [2:0] mod7(input logic [16:0] x);
        logic [5:0] a;
        logic [3:0] b;
        logic [2:0] c;
        begin
            a = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
                + {3'd0, x[14:12]} + {4'd0, x[16:15]};
            b = {1'b0, a[2:0]} + {1'b0, a[5:3]};
            c = (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
            c = (c == 3'd7) ? 3'd0 : c;
            return c;
        end
    endfunction

endpackage

// ===== rtl/packet_frame_parser.sv =====
//------------------------------------------------------------------------------
// packet_frame_parser
// Framed packet parser with optional WebSocket prefix, one byte per cycle.
//------------------------------------------------------------------------------
// Usage:
//   Input queue side: drive data_byte and end_of_buffer with push; an item is
//   taken when push is high and full is low. end_of_buffer marks the last byte
//   of a buffer; the next byte starts a new buffer.
//   Result queue side: while empty is low the oldest record is on the result
//   ports; pop takes it. record_kind 0 carries a body byte, 1 the status.
//   Configuration: websocket_mode at address 0 over the APB port, written
//   while idle; it is sampled on the first byte of each buffer.
// Timing:
//   One byte per cycle while the queue is not full. The front decodes each
//   byte combinationally into the two-entry queue at the edge that takes it;
//   the back stage registers the record when its output is empty or popped.
//   The front stalls only when the queue is full, i.e. when pop is held low.
// Reset:
//   All counters, sums, header capture and queues clear; websocket_mode is 0.
//------------------------------------------------------------------------------
module packet_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic        record_kind,
    output logic [7:0]  body_byte,
    output logic [3:0]  status,
    output logic [7:0]  packet_type,
    output logic [7:0]  packet_flag,
    output logic [15:0] route,
    output logic [31:0] sequence_no,
    output logic [7:0]  retry_count,
    output logic [31:0] user_id,
    output logic [31:0] session_key,
    output logic [31:0] protocol_word,
    output logic [15:0] decoded_length
);

    logic             ws_mode_reg;
    logic             f_valid, q_full, q_valid, q_take, b_valid;
    pfp_pkg::work_t   f_item, q_item;
    pfp_pkg::record_t rec;
    logic             accept;

    assign pready = 1'b1;
    assign prdata = (paddr == pfp_pkg::REG_WS_MODE) ? {31'd0, ws_mode_reg} : 32'd0;
    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ws_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == pfp_pkg::REG_WS_MODE)
            ws_mode_reg <= pwdata[0];
    end

    pfp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ws_mode       (ws_mode_reg),
        .in_valid      (accept),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .out_valid     (f_valid),
        .out_item      (f_item)
    );

    pfp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_valid),
        .wr_item  (f_item),
        .full     (q_full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    pfp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_take   (q_take),
        .out_valid (b_valid),
        .out_rec   (rec),
        .out_pop   (pop)
    );

    assign empty          = !b_valid;
    assign record_kind    = rec.kind;
    assign body_byte      = rec.body_byte;
    assign status         = rec.status;
    assign packet_type    = rec.packet_type;
    assign packet_flag    = rec.packet_flag;
    assign route          = rec.route;
    assign sequence_no    = rec.sequence_no;
    assign retry_count    = rec.retry_count;
    assign user_id        = rec.user_id;
    assign session_key    = rec.session_key;
    assign protocol_word  = rec.protocol_word;
    assign decoded_length = rec.decoded_length;

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !f_valid || !accept)
        else $error("item written into full queue");
    a_body_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !record_kind) |-> (status == 4'd0 && decoded_length == 16'd0))
        else $error("body record carries status fields");
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(body_byte) && $stable(status)))
        else $error("stalled record changed");
`endif

endmodule

// ===== rtl/pfp_front.sv =====
//------------------------------------------------------------------------------
// pfp_front
// Per-byte prefix decode, unmasking, header capture, sums and body select.
//------------------------------------------------------------------------------
module pfp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ws_mode,
    input  logic              in_valid,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    output logic              out_valid,
    output pfp_pkg::work_t    out_item
);

    logic [31:0] pos_reg;
    logic [3:0]  fhl_reg;
    logic [31:0] fpl_reg;
    logic [31:0] mask_reg;
    logic        wsa_reg;
    logic [3:0]  err_reg;
    logic [15:0] plen_reg;
    logic [7:0]  head_reg, tail_reg, hsum_reg, bsum_reg, ehs_reg, ebs_reg, bst_reg;
    logic [15:0] blen_reg;
    logic [63:0] hf0_reg, hf1_reg, hf2_reg;

    logic [31:0] pos_next, fpl_next, mask_next;
    logic [3:0]  fhl_next, err_next;
    logic        wsa;
    logic [15:0] plen_next, blen_next;
    logic [7:0]  head_next, tail_next, hsum_next, bsum_next, ehs_next, ebs_next, bst_next;
    logic [63:0] hf0_next, hf1_next, hf2_next;
    logic        pkt, emit;
    logic [31:0] q;
    logic [7:0]  v;
    logic [16:0] bo, bend;
    logic [6:0]  c;
    logic        qs;
    logic [4:0]  qi;

    always_comb
    begin
        wsa       = (pos_reg == 32'd0) ? ws_mode : wsa_reg;
        fhl_next  = fhl_reg;
        fpl_next  = fpl_reg;
        mask_next = mask_reg;
        err_next  = err_reg;
        plen_next = plen_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        hsum_next = hsum_reg;
        bsum_next = bsum_reg;
        ehs_next  = ehs_reg;
        ebs_next  = ebs_reg;
        bst_next  = bst_reg;
        blen_next = blen_reg;
        hf0_next  = hf0_reg;
        hf1_next  = hf1_reg;
        hf2_next  = hf2_reg;
        v         = data_byte;
        c         = data_byte[6:0];
        pkt       = 1'b1;
        q         = pos_reg;
        if (wsa)
        begin
            if (pos_reg == 32'd0)
            begin
                if (!data_byte[7])
                    err_next = pfp_pkg::ST_FIN;
                else if (data_byte[3:0] != 4'h2)
                    err_next = pfp_pkg::ST_OPCODE;
            end
            else if (pos_reg == 32'd1)
            begin
                if (err_reg == 4'd0 && !data_byte[7])
                    err_next = pfp_pkg::ST_MASK;
                if (c == 7'd126)
                    fhl_next = 4'd8;
                else if (c == 7'd127)
                    fhl_next = 4'd14;
                else
                begin
                    fhl_next = 4'd6;
                    fpl_next = {25'd0, c};
                end
            end
            else if (pos_reg + 32'd4 < {28'd0, fhl_reg})
            begin
                if (fpl_reg > 32'h00ffffff)
                    fpl_next = 32'hffffffff;
                else
                    fpl_next = {fpl_reg[23:0], data_byte};
            end
            else if (pos_reg < {28'd0, fhl_reg})
                mask_next = {mask_reg[23:0], data_byte};
            pkt = (pos_reg >= 32'd2) && (pos_reg >= {28'd0, fhl_reg});
            q   = pos_reg - {28'd0, fhl_reg};
            if (pkt && q < fpl_reg)
            begin
                case (q[1:0])
                    2'd0: v = data_byte ^ mask_reg[31:24];
                    2'd1: v = data_byte ^ mask_reg[23:16];
                    2'd2: v = data_byte ^ mask_reg[15:8];
                    default: v = data_byte ^ mask_reg[7:0];
                endcase
            end
        end

        bo   = (bst_reg == 8'd0) ? 17'(pfp_pkg::HDR_SIZE) : {9'd0, bst_reg};
        bend = bo + {1'b0, blen_reg};
        qs   = (q < 32'd32);
        qi   = q[4:0];
        emit = 1'b0;
        if (pkt)
        begin
            if (q == 32'd0)
                plen_next = {v, 8'd0};
            else if (q == 32'd1)
                plen_next = {plen_reg[15:8], v};
            else if (q == 32'd2)
                head_next = v;
            else if (q == 32'd3)
                ehs_next = v;
            if (q >= 32'd2 && q + 32'd1 == {16'd0, plen_reg})
                tail_next = v;
            if (q >= 32'd4 && q + 32'd1 < {16'd0, plen_reg})
                hsum_next = hsum_reg ^ v;
            if (qs)
            begin
                case (qi)
                    5'd4:  hf0_next[63:56] = v;
                    5'd5:  hf0_next[55:48] = v;
                    5'd6:  hf0_next[47:40] = v;
                    5'd7:  hf0_next[39:32] = v;
                    5'd8:  hf0_next[31:24] = v;
                    5'd9:  hf0_next[23:16] = v;
                    5'd10: hf0_next[15:8]  = v;
                    5'd11: hf0_next[7:0]   = v;
                    5'd12: hf1_next[39:32] = v;
                    5'd16: hf1_next[31:24] = v;
                    5'd17: hf1_next[23:16] = v;
                    5'd18: hf1_next[15:8]  = v;
                    5'd19: hf1_next[7:0]   = v;
                    5'd20: hf2_next[63:56] = v;
                    5'd21: hf2_next[55:48] = v;
                    5'd22: hf2_next[47:40] = v;
                    5'd23: hf2_next[39:32] = v;
                    5'd24: blen_next = {v, 8'd0};
                    5'd25: blen_next = {blen_reg[15:8], v};
                    5'd26: bst_next = v;
                    5'd27: ebs_next = v;
                    5'd28: hf2_next[31:24] = v;
                    5'd29: hf2_next[23:16] = v;
                    5'd30: hf2_next[15:8]  = v;
                    5'd31: hf2_next[7:0]   = v;
                    default: ;
                endcase
            end
            if (q >= 32'd28 && q < {15'd0, bend})
                bsum_next = bsum_reg ^ v;
            emit = (err_reg == 4'd0) && (plen_reg >= 16'd29) && (head_reg == pfp_pkg::HEAD_MAGIC)
                && !(bst_reg != 8'd0 && bst_reg < 8'd28) && (bend < {1'b0, plen_reg})
                && (q >= {15'd0, bo}) && (q < {15'd0, bend});
        end
        pos_next = (pos_reg == 32'hffffffff) ? pos_reg : pos_reg + 32'd1;
    end

    always_comb
    begin
        out_valid                        = in_valid && (end_of_buffer || emit);
        out_item.last                    = end_of_buffer;
        out_item.body_byte               = v;
        out_item.sum.ws_active           = wsa;
        out_item.sum.ws_short            = pos_next < 32'd14;
        out_item.sum.error_code          = err_next;
        out_item.sum.frame_over          = ({29'd0, fhl_next} + {1'b0, fpl_next})
                                           > {1'b0, pos_next};
        out_item.sum.size                = wsa ? pos_next - {28'd0, fhl_next} : pos_next;
        out_item.sum.packet_length       = plen_next;
        out_item.sum.head_byte           = head_next;
        out_item.sum.tail_byte           = tail_next;
        out_item.sum.header_sum          = hsum_next;
        out_item.sum.expected_header_sum = ehs_next;
        out_item.sum.body_sum            = bsum_next;
        out_item.sum.expected_body_sum   = ebs_next;
        out_item.sum.body_start          = bst_next;
        out_item.sum.body_length         = blen_next;
        out_item.sum.hf0                 = hf0_next;
        out_item.sum.hf1                 = hf1_next;
        out_item.sum.hf2                 = hf2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0; fhl_reg <= '0; fpl_reg <= '0; mask_reg <= '0; wsa_reg <= 1'b0;
            err_reg  <= '0; plen_reg <= '0; head_reg <= '0; tail_reg <= '0;
            hsum_reg <= '0; bsum_reg <= '0; ehs_reg <= '0; ebs_reg <= '0; bst_reg <= '0;
            blen_reg <= '0; hf0_reg <= '0; hf1_reg <= '0; hf2_reg <= '0;
        end
        else if (in_valid)
        begin
            if (end_of_buffer)
            begin
                pos_reg  <= '0; fhl_reg <= '0; fpl_reg <= '0; mask_reg <= '0;
                wsa_reg  <= 1'b0; err_reg <= '0; plen_reg <= '0; head_reg <= '0;
                tail_reg <= '0; hsum_reg <= '0; bsum_reg <= '0; ehs_reg <= '0;
                ebs_reg  <= '0; bst_reg <= '0; blen_reg <= '0;
                hf0_reg  <= '0; hf1_reg <= '0; hf2_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next; fhl_reg <= fhl_next; fpl_reg <= fpl_next;
                mask_reg <= mask_next; wsa_reg <= wsa; err_reg <= err_next;
                plen_reg <= plen_next; head_reg <= head_next; tail_reg <= tail_next;
                hsum_reg <= hsum_next; bsum_reg <= bsum_next; ehs_reg <= ehs_next;
                ebs_reg  <= ebs_next; bst_reg <= bst_next; blen_reg <= blen_next;
                hf0_reg  <= hf0_next; hf1_reg <= hf1_next; hf2_reg <= hf2_next;
            end
        end
    end

endmodule

// ===== rtl/pfp_queue.sv =====
//------------------------------------------------------------------------------
// pfp_queue
// Two-entry queue between the front and back parts.
//------------------------------------------------------------------------------
module pfp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  pfp_pkg::work_t    wr_item,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output pfp_pkg::work_t    rd_item
);

    pfp_pkg::work_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

// ===== rtl/pfp_back.sv =====
//------------------------------------------------------------------------------
// pfp_back
// Final status decision and result record register.
//------------------------------------------------------------------------------
module pfp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pfp_pkg::work_t    in_item,
    output logic              in_take,
    output logic              out_valid,
    output pfp_pkg::record_t  out_rec,
    input  logic              out_pop
);

    logic             valid_reg;
    pfp_pkg::record_t rec_reg;
    pfp_pkg::record_t rec_next;
    logic [3:0]       st;
    logic [16:0]      bend;
    pfp_pkg::summary_t s;

    assign in_take   = in_valid && (!valid_reg || out_pop);
    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

    always_comb
    begin
        s    = in_item.sum;
        bend = ((s.body_start == 8'd0) ? 17'(pfp_pkg::HDR_SIZE) : {9'd0, s.body_start})
               + {1'b0, s.body_length};
        if (s.ws_active && s.ws_short)
            st = pfp_pkg::ST_WS_SHORT;
        else if (s.ws_active && s.error_code != 4'd0)
            st = s.error_code;
        else if (s.ws_active && s.frame_over)
            st = pfp_pkg::ST_TRUNC;
        else if (s.size < 32'd2 || {16'd0, s.packet_length} > s.size)
            st = pfp_pkg::ST_TRUNC;
        else if (s.packet_length < 16'd29)
            st = pfp_pkg::ST_SHORT;
        else if (s.head_byte != pfp_pkg::HEAD_MAGIC)
            st = pfp_pkg::ST_HEAD;
        else if (s.tail_byte != pfp_pkg::TAIL_MAGIC)
            st = pfp_pkg::ST_TAIL;
        else if ((s.header_sum ^ pfp_pkg::salt(pfp_pkg::mod7({1'b0, s.packet_length} - 17'd5)))
                 != s.expected_header_sum)
            st = pfp_pkg::ST_HSUM;
        else if (s.body_start != 8'd0 && s.body_start < 8'd28)
            st = pfp_pkg::ST_OFFSET;
        else if (bend >= {1'b0, s.packet_length})
            st = pfp_pkg::ST_OVERRUN;
        else if ((s.body_sum ^ pfp_pkg::salt(pfp_pkg::mod7(bend - 17'd28)))
                 != s.expected_body_sum)
            st = pfp_pkg::ST_BSUM;
        else
            st = pfp_pkg::ST_OK;

        rec_next = '0;
        if (in_item.last)
        begin
            rec_next.kind   = 1'b1;
            rec_next.status = st;
            if (st == pfp_pkg::ST_OK)
            begin
                rec_next.packet_type   = s.hf0[63:56];
                rec_next.packet_flag   = s.hf0[55:48];
                rec_next.route         = s.hf0[47:32];
                rec_next.sequence_no   = s.hf0[31:0];
                rec_next.retry_count   = s.hf1[39:32];
                rec_next.user_id       = s.hf1[31:0];
                rec_next.session_key   = s.hf2[63:32];
                rec_next.protocol_word = s.hf2[31:0];
            end
            if (st == pfp_pkg::ST_OK || (st >= pfp_pkg::ST_HSUM && st <= pfp_pkg::ST_BSUM))
                rec_next.decoded_length = s.packet_length;
        end
        else
            rec_next.body_byte = in_item.body_byte;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_take)
            valid_reg <= 1'b1;
        else if (out_pop)
            valid_reg <= 1'b0;
    end

endmodule

// ===== tb/tb.sv =====
//------------------------------------------------------------------------------
// Packet frame parser testbench
// Streams buffers byte by byte into the parser, with and without the
// WebSocket prefix, predicts every body byte and status record, and checks
// each record field by field against the oldest prediction.
//------------------------------------------------------------------------------
module tb;

    localparam logic [7:0] SALT [7] = '{8'h74, 8'he8, 8'ha6, 8'h97, 8'h2e, 8'h3c, 8'h59};
    localparam logic [7:0] WS_FIN_BINARY = 8'h82;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        end_of_buffer;
    logic        empty;
    logic        pop;
    logic        record_kind;
    logic [7:0]  body_byte;
    logic [3:0]  status;
    logic [7:0]  packet_type;
    logic [7:0]  packet_flag;
    logic [15:0] route;
    logic [31:0] sequence_no;
    logic [7:0]  retry_count;
    logic [31:0] user_id;
    logic [31:0] session_key;
    logic [31:0] protocol_word;
    logic [15:0] decoded_length;

    packet_frame_parser u_dut (.*);

    // predictor state
    logic        ws_mode;
    logic [31:0] buf_pos;
    logic [3:0]  pre_len;
    logic [31:0] frame_len;
    logic [31:0] mask_word;
    logic [15:0] pkt_len;
    logic [7:0]  hdr_xor, body_xor, hdr_sum_rx, body_sum_rx, body_off;
    logic [15:0] body_len;
    logic [3:0]  pre_err;
    logic [63:0] hf [3];
    logic [7:0]  head_rx, tail_rx;
    logic        ws_on;

    pfp_pkg::record_t record_q [$];
    int          errors;
    int          records_seen;
    int          buffers_sent;
    int          send_idle;
    int          recv_idle;
    logic [7:0]  pkt [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_parse();
        buf_pos = 0; pre_len = 0; frame_len = 0; mask_word = 0; pkt_len = 0;
        hdr_xor = 0; body_xor = 0; hdr_sum_rx = 0; body_sum_rx = 0; body_off = 0;
        body_len = 0; pre_err = 0; head_rx = 0; tail_rx = 0; ws_on = 0;
        hf[0] = 0; hf[1] = 0; hf[2] = 0;
    endtask

    function automatic logic [31:0] body_begin();
        return (body_off == 0) ? 32'd28 : {24'd0, body_off};
    endfunction

    task automatic take_packet_byte(input logic [31:0] q, input logic [7:0] v);
        logic [31:0] stop;
        stop = body_begin() + body_len;
        if (q == 0) pkt_len = {v, 8'h00};
        else if (q == 1) pkt_len[7:0] = v;
        else if (q == 2) head_rx = v;
        else if (q == 3) hdr_sum_rx = v;
        if (q >= 2 && q + 1 == {16'd0, pkt_len}) tail_rx = v;
        if (q >= 4 && q + 1 < {16'd0, pkt_len}) hdr_xor ^= v;
        if (q >= 4 && q <= 11) hf[0][8*(11-q) +: 8] = v;
        else if (q == 12) hf[1][39:32] = v;
        else if (q >= 16 && q <= 19) hf[1][8*(19-q) +: 8] = v;
        else if (q >= 20 && q <= 23) hf[2][32 + 8*(23-q) +: 8] = v;
        else if (q == 24) body_len = {v, 8'h00};
        else if (q == 25) body_len[7:0] = v;
        else if (q == 26) body_off = v;
        else if (q == 27) body_sum_rx = v;
        else if (q >= 28 && q <= 31) hf[2][8*(31-q) +: 8] = v;
        if (q >= 28 && q < stop) body_xor ^= v;
    endtask

    function automatic bit body_due(input logic [31:0] q);
        logic [31:0] stop;
        stop = body_begin() + body_len;
        if (pre_err != 0) return 0;
        if (pkt_len < 29 || head_rx != pfp_pkg::HEAD_MAGIC) return 0;
        if (body_off != 0 && body_off < 28) return 0;
        if (stop >= {16'd0, pkt_len}) return 0;
        return q >= body_begin() && q < stop;
    endfunction

    function automatic pfp_pkg::status_t buffer_verdict();
        logic [32:0] size;
        logic [31:0] stop;
        size = {1'b0, buf_pos};
        if (ws_on)
        begin
            if (size < 14) return pfp_pkg::ST_WS_SHORT;
            if (pre_err != 0) return pfp_pkg::status_t'(pre_err);
            if ({29'd0, pre_len} + {1'b0, frame_len} > size) return pfp_pkg::ST_TRUNC;
            size -= pre_len;
        end
        if (size < 2 || {17'd0, pkt_len} > size) return pfp_pkg::ST_TRUNC;
        if (pkt_len < 29) return pfp_pkg::ST_SHORT;
        if (head_rx != pfp_pkg::HEAD_MAGIC) return pfp_pkg::ST_HEAD;
        if (tail_rx != pfp_pkg::TAIL_MAGIC) return pfp_pkg::ST_TAIL;
        if ((hdr_xor ^ SALT[(pkt_len - 5) % 7]) != hdr_sum_rx) return pfp_pkg::ST_HSUM;
        if (body_off != 0 && body_off < 28) return pfp_pkg::ST_OFFSET;
        stop = body_begin() + body_len;
        if (stop >= {16'd0, pkt_len}) return pfp_pkg::ST_OVERRUN;
        if ((body_xor ^ SALT[(stop - 28) % 7]) != body_sum_rx) return pfp_pkg::ST_BSUM;
        return pfp_pkg::ST_OK;
    endfunction

    task automatic predict_byte(input logic [7:0] din, input logic last);
        logic [7:0]        v;
        logic [31:0]       p, i;
        logic [6:0]        c;
        pfp_pkg::record_t  r;
        bit                emit;
        pfp_pkg::status_t  st;
        v = din; p = buf_pos; emit = 0; r = '0;
        if (p == 0) ws_on = ws_mode;
        if (ws_on)
        begin
            if (p == 0)
            begin
                if (!v[7]) pre_err = pfp_pkg::ST_FIN;
                else if (v[3:0] != 4'h2) pre_err = pfp_pkg::ST_OPCODE;
            end
            else if (p == 1)
            begin
                c = v[6:0];
                if (pre_err == 0 && !v[7]) pre_err = pfp_pkg::ST_MASK;
                if (c == 126) pre_len = 8;
                else if (c == 127) pre_len = 14;
                else
                begin
                    pre_len = 6;
                    frame_len = {25'd0, c};
                end
            end
            else if (p + 4 < pre_len)
            begin
                if (frame_len > 32'h00ffffff) frame_len = 32'hffffffff;
                else frame_len = {frame_len[23:0], v};
            end
            else if (p < pre_len)
                mask_word = {mask_word[23:0], v};
            if (p >= 2 && p >= pre_len)
            begin
                i = p - pre_len;
                if (i < frame_len) v ^= mask_word[8*(3 - i[1:0]) +: 8];
                take_packet_byte(i, v);
                emit = !last && body_due(i);
            end
        end
        else
        begin
            take_packet_byte(p, v);
            emit = !last && body_due(p);
        end
        if (buf_pos != 32'hffffffff) buf_pos++;
        if (last)
        begin
            st = buffer_verdict();
            r.kind = 1'b1;
            r.status = st;
            if (st == pfp_pkg::ST_OK)
            begin
                r.packet_type   = hf[0][63:56];
                r.packet_flag   = hf[0][55:48];
                r.route         = hf[0][47:32];
                r.sequence_no   = hf[0][31:0];
                r.retry_count   = hf[1][39:32];
                r.user_id       = hf[1][31:0];
                r.session_key   = hf[2][63:32];
                r.protocol_word = hf[2][31:0];
            end
            if (st == pfp_pkg::ST_OK || (st >= pfp_pkg::ST_HSUM && st <= pfp_pkg::ST_BSUM))
                r.decoded_length = pkt_len;
            record_q.push_back(r);
            clear_parse();
        end
        else if (emit)
        begin
            r.body_byte = v;
            record_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // result side
    always @(posedge clk)
    begin
        pfp_pkg::record_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                records_seen++;
                if (record_q.size() == 0)
                    report_mismatch("unexpected record", record_kind, 0);
                else
                begin
                    want = record_q.pop_front();
                    if (record_kind !== want.kind) report_mismatch("kind", record_kind, want.kind);
                    if (body_byte !== want.body_byte)
                        report_mismatch("body_byte", body_byte, want.body_byte);
                    if (status !== want.status) report_mismatch("status", status, want.status);
                    if (packet_type !== want.packet_type)
                        report_mismatch("packet_type", packet_type, want.packet_type);
                    if (packet_flag !== want.packet_flag)
                        report_mismatch("packet_flag", packet_flag, want.packet_flag);
                    if (route !== want.route) report_mismatch("route", route, want.route);
                    if (sequence_no !== want.sequence_no)
                        report_mismatch("sequence_no", sequence_no, want.sequence_no);
                    if (retry_count !== want.retry_count)
                        report_mismatch("retry_count", retry_count, want.retry_count);
                    if (user_id !== want.user_id) report_mismatch("user_id", user_id, want.user_id);
                    if (session_key !== want.session_key)
                        report_mismatch("session_key", session_key, want.session_key);
                    if (protocol_word !== want.protocol_word)
                        report_mismatch("protocol_word", protocol_word, want.protocol_word);
                    if (decoded_length !== want.decoded_length)
                        report_mismatch("decoded_length", decoded_length, want.decoded_length);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // hold push high after the item; the next call or drain() replaces or drops it
    task automatic send_byte(input logic [7:0] v, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= v;
        end_of_buffer <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_byte(v, last);
    endtask

    // send a whole buffer, optionally wrapped in a masked frame prefix
    task automatic send_buffer(input bit wrap, input int extra_len);
        logic [31:0] key;
        int plen;
        plen = pkt.size() + extra_len;
        key = $urandom();
        if (wrap)
        begin
            send_byte(WS_FIN_BINARY, 0);
            if (plen < 126) send_byte({1'b1, 7'(plen)}, 0);
            else
            begin
                send_byte(8'hfe, 0);
                send_byte(8'(plen >> 8), 0);
                send_byte(8'(plen), 0);
            end
            for (int k = 0; k < 4; k++) send_byte(key[8*(3-k) +: 8], 0);
        end
        for (int k = 0; k < pkt.size(); k++)
            send_byte(wrap ? pkt[k] ^ key[8*(3 - k%4) +: 8] : pkt[k], k == pkt.size() - 1);
        buffers_sent++;
    endtask

    // build a well-formed packet into pkt; faults are injected by the caller
    task automatic build_packet(input int body_n, input int offset);
        int len, start;
        logic [7:0] hx, bx;
        start = (offset == 0) ? 28 : offset;
        len = start + body_n + 1 + $urandom_range(2);
        pkt.delete();
        pkt.push_back(8'(len >> 8));
        pkt.push_back(8'(len));
        pkt.push_back(pfp_pkg::HEAD_MAGIC);
        pkt.push_back(8'h00);
        for (int k = 4; k < len; k++) pkt.push_back(8'($urandom()));
        pkt[24] = 8'(body_n >> 8);
        pkt[25] = 8'(body_n);
        pkt[26] = 8'(offset);
        pkt[len-1] = pfp_pkg::TAIL_MAGIC;
        bx = 0;
        for (int k = 28; k < start + body_n; k++) bx ^= pkt[k];
        pkt[27] = bx ^ SALT[(start + body_n - 28) % 7];
        hx = 0;
        for (int k = 4; k < len - 1; k++) hx ^= pkt[k];
        pkt[3] = hx ^ SALT[(len - 5) % 7];
    endtask

    task automatic write_mode(input logic m);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= pfp_pkg::REG_WS_MODE;
        pwdata <= {31'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        ws_mode = m;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (record_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic send_random_raw(input int n);
        for (int k = 0; k < n; k++) send_byte(8'($urandom()), k == n - 1);
        buffers_sent++;
    endtask

    task automatic test_plain_directed();
        build_packet(3, 0);
        send_buffer(0, 0);
        build_packet(0, 0);
        send_buffer(0, 0);
        build_packet(2, 30);
        pkt[29] = 8'hff;
        pkt[30] = 8'h00;
        send_buffer(0, 0);
        send_byte(8'h00, 1);
        send_byte(8'hff, 0);
        send_byte(8'hff, 1);
        buffers_sent += 2;
        build_packet(1, 0);
        pkt[2] = 8'h80;
        send_buffer(0, 0);
        build_packet(1, 0);
        pkt[0] = 8'h00; pkt[1] = 8'd20;
        send_buffer(0, 0);
    endtask

    task automatic test_ws_directed();
        build_packet(2, 0);
        send_buffer(1, 0);
        build_packet(1, 0);
        send_buffer(1, 40);
        send_random_raw(5);
        send_byte(8'h02, 0);
        for (int k = 0; k < 14; k++) send_byte(8'($urandom()), k == 13);
        buffers_sent++;
        send_byte(8'h81, 0);
        for (int k = 0; k < 14; k++) send_byte(8'($urandom()), k == 13);
        buffers_sent++;
        send_byte(WS_FIN_BINARY, 0);
        send_byte(8'h05, 0);
        for (int k = 0; k < 14; k++) send_byte(8'($urandom()), k == 13);
        buffers_sent++;
        send_byte(WS_FIN_BINARY, 0);
        send_byte(8'hff, 0);
        for (int k = 0; k < 20; k++) send_byte(8'hff, k == 19);
        buffers_sent++;
    endtask

    task automatic test_random(input int bytes_target, input bit wrap);
        int sent, kind;
        sent = 0;
        while (sent < bytes_target)
        begin
            kind = $urandom_range(9);
            if (kind < 7)
            begin
                build_packet($urandom_range(6), ($urandom_range(3) == 0) ? 28 + $urandom_range(3) : 0);
                case ($urandom_range(9))
                    0: pkt[$urandom_range(pkt.size() - 1)] ^= 8'(1 << $urandom_range(7));
                    1: pkt.pop_back();
                    2: pkt[26] = 8'($urandom_range(27));
                    3: pkt[25] = 8'($urandom());
                    default: ;
                endcase
                sent += pkt.size();
                send_buffer(wrap, 0);
            end
            else
            begin
                kind = 1 + $urandom_range(40);
                sent += kind;
                send_random_raw(kind);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0; clk = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; push = 1'b0; data_byte = '0; end_of_buffer = 1'b0; pop = 1'b0;
        errors = 0; records_seen = 0; buffers_sent = 0; ws_mode = 1'b0;
        send_idle = 19; recv_idle = 74;
        clear_parse();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_directed();
        drain();
        write_mode(1'b1);
        test_ws_directed();
        drain();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 19 : (ph == 1) ? 74 : 0;
            recv_idle = (ph == 0) ? 74 : (ph == 1) ? 19 : 0;
            write_mode(1'b0);
            test_random(60, 0);
            drain();
            write_mode(1'b1);
            test_random(60, 1);
            drain();
        end
        drain();
        $display("covered %0d buffers, %0d records, both framing modes", buffers_sent, records_seen);
        if (errors == 0 && record_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pfp_pkg.sv
rtl/pfp_front.sv
rtl/pfp_queue.sv
rtl/pfp_back.sv
rtl/packet_frame_parser.sv
tb/tb.sv
